### sv/gfbs_pkg.sv
// Package for the grouped free-block stack: operation and result codes,
// controller states and the shift control word of the cell chain.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none
package gfbs_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 6;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FILL   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_SPILL  = 2'd1,
    KIND_FILLED = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RUN,
    ST_SPILL
  } state_t;

  typedef struct packed {
    logic down;
    logic up;
  } shift_t;

endpackage
`default_nettype wire

### sv/gfbs_cell.sv
// One stack cell of the grouped free-block stack chain: holds one entry and
// takes its neighbour's entry when the chain shifts. Uses gfbs_pkg.
`default_nettype none
module gfbs_cell (
  input  wire logic                          clk,
  input  wire gfbs_pkg::shift_t              ctl,
  input  wire logic [gfbs_pkg::WORD_W-1:0]   left_i,
  input  wire logic [gfbs_pkg::WORD_W-1:0]   right_i,
  output logic      [gfbs_pkg::WORD_W-1:0]   q
);

  logic [gfbs_pkg::WORD_W-1:0] data_r;
  logic [gfbs_pkg::WORD_W-1:0] data_nxt;

  always_comb begin
    priority if (ctl.down) begin
      data_nxt = left_i;
    end else if (ctl.up) begin
      data_nxt = right_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
`default_nettype wire

### sv/grouped_free_block_stack.sv
// Top level of the grouped free-block stack: controller, result register and
// a chain of gfbs_cell stages holding the in-core stack. Uses gfbs_pkg.
//
// The stack lives in a chain of STACK_DEPTH cells with the top entry in the
// first cell: an allocation pops it and shifts the chain up, a free shifts
// the chain down and puts the freed block in the first cell. A free on a
// full stack spills STACK_DEPTH+1 result transactions, one per cycle while
// the output is not stalled, as the chain shifts its deepest entry out, and
// takes no input until the last one is loaded. After reset, and after an
// allocation that empties the stack, the block expects STACK_DEPTH+1 fill
// words: the top index and then the entries from the bottom up. No clearing
// pass is needed after reset.
`default_nettype none
module grouped_free_block_stack #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // freed_block[31:0], fill_data[63:32]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // block_number[31:0], word_index[37:32],
                                       // word_data[69:38], zero[71:70]
  output logic      [2:0]  out_tuser,  // kind[1:0], needs_fill[2]
  output logic             out_tlast
);

  localparam int unsigned TW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WW  = gfbs_pkg::WORD_W;

  logic [WW-1:0] cell_q [STACK_DEPTH];
  logic [WW-1:0] chain_in;
  gfbs_pkg::shift_t shift_ctl;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WW-1:0] left_d;
    logic [WW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = chain_in;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    gfbs_cell u_cell (
      .clk     (clk),
      .ctl     (shift_ctl),
      .left_i  (left_d),
      .right_i (right_d),
      .q       (cell_q[i])
    );
  end

  gfbs_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]  top_r, top_nxt;
  logic [FPW-1:0] fill_pos_r, fill_pos_nxt;
  logic [FPW-1:0] spill_idx_r, spill_idx_nxt;
  logic [WW-1:0]  spill_blk_r, spill_blk_nxt;

  logic                     out_valid_r, out_valid_nxt;
  gfbs_pkg::kind_t          out_kind_r, out_kind_nxt;
  logic [WW-1:0]            out_blk_r, out_blk_nxt;
  logic                     out_need_r, out_need_nxt;
  logic [gfbs_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [WW-1:0]            out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  logic          out_free;
  logic          in_acc;
  gfbs_pkg::op_t in_op;
  logic [WW-1:0] freed_block;
  logic [WW-1:0] fill_data;
  logic [TW-1:0] fill_top;

  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r != gfbs_pkg::ST_SPILL) && out_free;
  assign in_acc      = in_tvalid && in_tready;
  assign in_op       = gfbs_pkg::op_t'(in_tuser);
  assign freed_block = in_tdata[31:0];
  assign fill_data   = in_tdata[63:32];
  assign fill_top    = (fill_data >= WW'(STACK_DEPTH)) ? TW'(STACK_DEPTH - 1)
                                                       : fill_data[TW-1:0];

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    fill_pos_nxt  = fill_pos_r;
    spill_idx_nxt = spill_idx_r;
    spill_blk_nxt = spill_blk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_blk_nxt   = out_blk_r;
    out_need_nxt  = out_need_r;
    out_idx_nxt   = out_idx_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    shift_ctl     = '0;
    chain_in      = freed_block;

    unique case (state_r)
      gfbs_pkg::ST_FILL: begin
        if (in_acc) begin
          unique case (in_op)
            gfbs_pkg::OP_FILL: begin
              chain_in = fill_data;
              if (fill_pos_r == '0) begin
                top_nxt = fill_top;
              end else if (fill_pos_r <= FPW'(top_r) + FPW'(1)) begin
                shift_ctl.down = 1'b1;
              end
              fill_pos_nxt = fill_pos_r + FPW'(1);
              if (fill_pos_r == FPW'(STACK_DEPTH)) begin
                state_nxt     = gfbs_pkg::ST_RUN;
                fill_pos_nxt  = '0;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gfbs_pkg::KIND_FILLED;
                out_blk_nxt   = '0;
                out_need_nxt  = 1'b0;
                out_idx_nxt   = '0;
                out_data_nxt  = '0;
                out_last_nxt  = 1'b1;
              end
            end
            gfbs_pkg::OP_ALLOC, gfbs_pkg::OP_FREE: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = gfbs_pkg::KIND_REJECT;
              out_blk_nxt   = '0;
              out_need_nxt  = 1'b0;
              out_idx_nxt   = '0;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      gfbs_pkg::ST_RUN: begin
        if (in_acc) begin
          unique case (in_op)
            gfbs_pkg::OP_ALLOC: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = gfbs_pkg::KIND_ALLOC;
              out_blk_nxt   = cell_q[0];
              out_idx_nxt   = '0;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (top_r == '0) begin
                out_need_nxt = 1'b1;
                state_nxt    = gfbs_pkg::ST_FILL;
                fill_pos_nxt = '0;
              end else begin
                out_need_nxt = 1'b0;
                top_nxt      = top_r - TW'(1);
                shift_ctl.up = 1'b1;
              end
            end
            gfbs_pkg::OP_FREE: begin
              if (top_r == TW'(STACK_DEPTH - 1)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gfbs_pkg::KIND_SPILL;
                out_blk_nxt   = freed_block;
                out_need_nxt  = 1'b0;
                out_idx_nxt   = '0;
                out_data_nxt  = WW'(STACK_DEPTH - 1);
                out_last_nxt  = 1'b0;
                spill_blk_nxt = freed_block;
                spill_idx_nxt = FPW'(1);
                state_nxt     = gfbs_pkg::ST_SPILL;
              end else begin
                top_nxt        = top_r + TW'(1);
                shift_ctl.down = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gfbs_pkg::ST_SPILL: begin
        chain_in = spill_blk_r;
        if (out_free) begin
          shift_ctl.down = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = gfbs_pkg::KIND_SPILL;
          out_blk_nxt    = spill_blk_r;
          out_need_nxt   = 1'b0;
          out_idx_nxt    = gfbs_pkg::IDX_W'(spill_idx_r);
          out_data_nxt   = cell_q[STACK_DEPTH-1];
          out_last_nxt   = (spill_idx_r == FPW'(STACK_DEPTH));
          if (spill_idx_r == FPW'(STACK_DEPTH)) begin
            state_nxt = gfbs_pkg::ST_RUN;
            top_nxt   = '0;
          end else begin
            spill_idx_nxt = spill_idx_r + FPW'(1);
          end
        end
      end
      default: begin
        state_nxt = gfbs_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfbs_pkg::ST_FILL;
      top_r       <= '0;
      fill_pos_r  <= '0;
      spill_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      fill_pos_r  <= fill_pos_nxt;
      spill_idx_r <= spill_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spill_blk_r <= spill_blk_nxt;
    out_kind_r  <= out_kind_nxt;
    out_blk_r   <= out_blk_nxt;
    out_need_r  <= out_need_nxt;
    out_idx_r   <= out_idx_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r, out_idx_r, out_blk_r};
  assign out_tuser  = {out_need_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### bench/tb_grouped_free_block_stack.sv
// Self-checking testbench for grouped_free_block_stack: directed and random
// allocate, free and fill traffic, checked against an in-bench free-list tracker.
// Depends on gfbs_pkg and the grouped_free_block_stack RTL only.
module tb_grouped_free_block_stack;

  localparam int GS          = 32;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]      pad;
    gfbs_pkg::kind_t kind;
    logic [31:0]     blk;
    logic            need;
    logic [5:0]      idx;
    logic [31:0]     data;
    logic            last;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  logic [31:0] free_stack [GS];
  int          free_top  = 0;
  bit          refilling = 1'b1;
  int          fill_pos  = 0;
  result_t     due_results [$];

  int idle_pct    = 0;
  int stall_pct   = 0;
  int fail_count  = 0;
  int quiet_cycles = 0;
  int items_sent  = 0;
  int n_alloc     = 0;
  int n_spill     = 0;
  int n_refill    = 0;
  int n_reject    = 0;

  grouped_free_block_stack #(.STACK_DEPTH(GS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void queue_result(gfbs_pkg::kind_t kind, logic [31:0] blk,
                                       logic need, logic [5:0] idx,
                                       logic [31:0] data, logic last);
    result_t r;
    r.pad  = 2'b00;
    r.kind = kind;
    r.blk  = blk;
    r.need = need;
    r.idx  = idx;
    r.data = data;
    r.last = last;
    due_results.push_back(r);
  endfunction

  task automatic track_free_list(gfbs_pkg::op_t op, logic [31:0] blk, logic [31:0] word);
    int t;
    t = free_top;
    case (op)
      gfbs_pkg::OP_UNUSED: begin
      end
      gfbs_pkg::OP_FILL: begin
        if (refilling) begin
          if (fill_pos == 0) free_top = (word >= GS) ? GS - 1 : int'(word);
          else free_stack[fill_pos - 1] = word;
          fill_pos++;
          if (fill_pos > GS) begin
            refilling = 1'b0;
            fill_pos  = 0;
            n_refill++;
            queue_result(gfbs_pkg::KIND_FILLED, '0, 1'b0, '0, '0, 1'b1);
          end
        end
      end
      default: begin
        if (refilling) begin
          n_reject++;
          queue_result(gfbs_pkg::KIND_REJECT, '0, 1'b0, '0, '0, 1'b1);
        end else if (op == gfbs_pkg::OP_ALLOC) begin
          n_alloc++;
          if (t > 0) begin
            free_top = t - 1;
            queue_result(gfbs_pkg::KIND_ALLOC, free_stack[t], 1'b0, '0, '0, 1'b1);
          end else begin
            refilling = 1'b1;
            fill_pos  = 0;
            queue_result(gfbs_pkg::KIND_ALLOC, free_stack[t], 1'b1, '0, '0, 1'b1);
          end
        end else if (t == GS - 1) begin
          n_spill++;
          queue_result(gfbs_pkg::KIND_SPILL, blk, 1'b0, '0, 32'(t), 1'b0);
          for (int i = 0; i < GS; i++)
            queue_result(gfbs_pkg::KIND_SPILL, blk, 1'b0, 6'(i + 1), free_stack[i],
                         i == GS - 1);
          free_stack[0] = blk;
          free_top      = 0;
        end else begin
          free_top = t + 1;
          free_stack[t + 1] = blk;
        end
      end
    endcase
  endtask

  task automatic send_op(gfbs_pkg::op_t op, logic [31:0] blk, logic [31:0] word);
    while ($urandom_range(99) < idle_pct) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {word, blk};
    do @(posedge clk); while (!in_tready);
    track_free_list(op, blk, word);
    items_sent++;
  endtask

  function automatic logic [31:0] random_block();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [31:0] random_top_index();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GS - 1;
      2:       return GS;
      3:       return '1;
      4:       return $urandom_range(GS - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_stack(logic [31:0] top_word);
    logic [31:0] w;
    send_op(gfbs_pkg::OP_FILL, random_block(), top_word);
    for (int i = 0; i < GS; i++) begin
      case (i % 4)
        0:       w = '0;
        1:       w = '1;
        2:       w = 32'hA5A5_5A5A ^ i;
        default: w = $urandom;
      endcase
      send_op(gfbs_pkg::OP_FILL, random_block(), w);
    end
  endtask

  // reject alloc and free while the initial fill is outstanding
  task automatic test_reject_while_filling();
    send_op(gfbs_pkg::OP_ALLOC, '1, '1);
    send_op(gfbs_pkg::OP_FREE, 32'h1234_5678, '0);
    send_op(gfbs_pkg::OP_UNUSED, '1, '1);
  endtask

  task automatic test_initial_fill();
    fill_stack('1);
  endtask

  task automatic test_ignored_ops();
    send_op(gfbs_pkg::OP_FILL, '0, 32'h0000_0005);
    send_op(gfbs_pkg::OP_UNUSED, '0, '0);
  endtask

  task automatic test_full_stack_spill();
    send_op(gfbs_pkg::OP_FREE, '1, '0);
    send_op(gfbs_pkg::OP_FREE, '0, '1);
  endtask

  task automatic test_alloc_until_empty();
    send_op(gfbs_pkg::OP_ALLOC, $urandom, $urandom);
    send_op(gfbs_pkg::OP_ALLOC, $urandom, $urandom);
    send_op(gfbs_pkg::OP_ALLOC, $urandom, $urandom);
    fill_stack(GS);
  endtask

  task automatic test_random_traffic(int items, int idle, int stall);
    int            done_items;
    int            r;
    int            free_bias;
    gfbs_pkg::op_t op;
    logic [31:0]   blk;
    logic [31:0]   word;
    idle_pct   = idle;
    stall_pct  = stall;
    done_items = 0;
    free_bias  = 50;
    while (done_items < items) begin
      if ($urandom_range(19) == 0) free_bias = $urandom_range(1) ? 80 : 20;
      r    = $urandom_range(99);
      blk  = random_block();
      word = random_block();
      if (refilling) begin
        if (r < 3)      op = gfbs_pkg::OP_ALLOC;
        else if (r < 6) op = gfbs_pkg::OP_FREE;
        else if (r < 8) op = gfbs_pkg::OP_UNUSED;
        else            op = gfbs_pkg::OP_FILL;
        if (fill_pos == 0) word = random_top_index();
      end else begin
        if (r < 3)      op = gfbs_pkg::OP_UNUSED;
        else if (r < 6) op = gfbs_pkg::OP_FILL;
        else if ($urandom_range(99) < free_bias) op = gfbs_pkg::OP_FREE;
        else            op = gfbs_pkg::OP_ALLOC;
      end
      if (!(op == gfbs_pkg::OP_UNUSED || (op == gfbs_pkg::OP_FILL && !refilling)))
        done_items++;
      send_op(op, blk, word);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[71:70], gfbs_pkg::kind_t'(out_tuser[1:0]), out_tdata[31:0],
             out_tuser[2], out_tdata[37:32], out_tdata[69:38], out_tlast};
      if (due_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result kind %0d blk %h idx %0d data %h last %b",
                 $time, got.kind, got.blk, got.idx, got.data, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: expected kind %0d blk %h need %b idx %0d data %h last %b pad %b",
                   $time, want.kind, want.blk, want.need, want.idx, want.data, want.last,
                   want.pad);
          $display("%0t: actual   kind %0d blk %h need %b idx %0d data %h last %b pad %b",
                   $time, got.kind, got.blk, got.need, got.idx, got.data, got.last, got.pad);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, due_results.size());
      $display("** grouped_free_block_stack: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reject_while_filling();
    test_initial_fill();
    test_ignored_ops();
    test_full_stack_spill();
    test_alloc_until_empty();

    test_random_traffic(42, 0, 0);
    test_random_traffic(42, 72, 0);
    test_random_traffic(42, 0, 72);
    test_random_traffic(42, 22, 22);

    @(negedge clk) in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (2 * GS + 8) @(posedge clk);

    if (due_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    $display("Ran %0d input transactions through fills, pushes, pops and rejections:",
             items_sent);
    $display("  %0d allocations, %0d full-stack spills, %0d completed fills, %0d rejections",
             n_alloc, n_spill, n_refill, n_reject);
    if (fail_count == 0) begin
      $display("** grouped_free_block_stack: PASSED **");
    end else begin
      $display("** grouped_free_block_stack: FAILED **");
    end
    $finish;
  end

endmodule
